// ===== rtl/core/tmtg_pkg.sv =====
package tmtg_pkg;

  // Width used for all position and limit comparisons.
  localparam int CMP_W = 12;

  // Channels per pixel and the largest channel byte.
  localparam int NUM_CHAN = 3;
  localparam int BYTE_MAX = 255;

  // Width of the per-pixel sum of three channel bytes.
  localparam int ADD_W = 10;

  // A mask byte above this value drops its channel from the sum.
  localparam logic [7:0] MASK_LIMIT = 8'd128;

  // Largest value of the active tile tally.
  localparam logic [13:0] TALLY_MAX = 14'h3FFF;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TILE_COLS   = 3'd0;
  localparam logic [2:0] REG_TILE_WIDTH  = 3'd1;
  localparam logic [2:0] REG_TILE_HEIGHT = 3'd2;
  localparam logic [2:0] REG_TILE_ROWS   = 3'd3;
  localparam logic [2:0] REG_THRESHOLD   = 3'd4;
  localparam logic [2:0] REG_MASK_ENABLE = 3'd5;

  // Divider sequencer states.
  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_HOLD = 3'b100
  } div_state_t;

  // Identity of a tile on its way through the divider.
  typedef struct packed {
    logic [6:0] row;
    logic [5:0] col;
    logic       last;
  } tile_tag_t;

  // A zero register acts as one, and a value above the maximum saturates.
  function automatic logic [CMP_W-1:0] clamp_reg(input logic [CMP_W-1:0] v,
                                                 input logic [CMP_W-1:0] maxv);
    logic [CMP_W-1:0] r;
    if (v == '0) begin
      r = CMP_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Channel byte after masking.
  function automatic logic [7:0] masked_byte(input logic [7:0] chan,
                                             input logic [7:0] mask,
                                             input logic       en);
    logic [7:0] r;
    r = (en && (mask > MASK_LIMIT)) ? 8'd0 : chan;
    return r;
  endfunction

endpackage

// ===== rtl/core/tmtg_sum_ram.sv =====
module tmtg_sum_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 21
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);

  logic [DW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] written;

  // Storage array with one write and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= written[rd_addr] ? mem[rd_addr] : '0;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/tmtg_div.sv =====
module tmtg_div import tmtg_pkg::*; #(
  parameter int SUM_W = 21,
  parameter int DV_W  = 13
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [DV_W-1:0]  divisor,
  output logic             busy,
  output logic             q_valid,
  input  logic             q_ready,
  output logic [SUM_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  div_state_t       state;
  div_state_t       state_next;
  logic [CNT_W-1:0] count;
  logic [DV_W-1:0]  rem;
  logic [DV_W-1:0]  dvs;
  logic [DV_W:0]    rem_sh;
  logic             fits;

  assign busy     = (state != DIV_IDLE);
  assign q_valid  = (state == DIV_HOLD);

  // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem, quotient[SUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, dvs});

  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = DIV_RUN;
      DIV_RUN:  if (count == CNT_W'(1)) state_next = DIV_HOLD;
      DIV_HOLD: if (q_ready) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath: the quotient register first holds the dividend and fills from the bottom.
  always_ff @(posedge clk) begin
    if (state == DIV_IDLE && start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      count    <= CNT_W'(SUM_W);
    end else if (state == DIV_RUN) begin
      rem      <= fits ? DV_W'(rem_sh - {1'b0, dvs}) : DV_W'(rem_sh);
      quotient <= {quotient[SUM_W-2:0], fits};
      count    <= count - CNT_W'(1);
    end
  end

endmodule

// ===== rtl/core/tile_mean_threshold_grid_top.sv =====
// Tile mean threshold grid.
// Pixels enter on the pix channel (pix_valid/pix_ready) in raster order, one
// beat per pixel, with start_of_frame high on the first pixel of a frame.
// Each completed tile leaves as one beat on the tile channel
// (tile_valid/tile_ready) carrying its band and column, floored mean, active
// flag, running active count and a last-tile flag.
// Pixels are taken at one per cycle. Each pixel inside the frame does a
// read-modify-write of its column sum in the column sum memory; back-to-back
// hits on one column are forwarded. A tile's mean comes from a one-bit-per-cycle
// divider and is offered from the output register. The divider holds one tile at
// a time: a pixel that may complete a tile waits while the previous tile is still
// in the accumulate stage or the divider.
// A stalled receiver leaves the finished result in the output register; the
// divider then holds the next tile and pixels keep flowing until another
// tile would complete.
// Reset loads the register defaults, clears the position and tally, and
// marks every column sum as zero; no clearing pass is needed.
module tile_mean_threshold_grid_top import tmtg_pkg::*; #(
  parameter int MAX_TILE_COLS   = 64,
  parameter int MAX_TILE_WIDTH  = 32,
  parameter int MAX_TILE_HEIGHT = 64,
  parameter int MAX_TILE_ROWS   = 128
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Pixel channel.
  input  logic        pix_valid,
  output logic        pix_ready,
  input  logic        start_of_frame,
  input  logic [7:0]  chan0,
  input  logic [7:0]  chan1,
  input  logic [7:0]  chan2,
  input  logic [7:0]  mask0,
  input  logic [7:0]  mask1,
  input  logic [7:0]  mask2,
  // Tile channel.
  output logic        tile_valid,
  input  logic        tile_ready,
  output logic [6:0]  tile_row,
  output logic [5:0]  tile_col,
  output logic [7:0]  tile_mean,
  output logic        tile_active,
  output logic [13:0] active_count,
  output logic        last_tile
);

  localparam int AW    = (MAX_TILE_COLS > 1) ? $clog2(MAX_TILE_COLS) : 1;
  localparam int PW    = (MAX_TILE_WIDTH > 1) ? $clog2(MAX_TILE_WIDTH) : 1;
  localparam int RW    = (MAX_TILE_HEIGHT > 1) ? $clog2(MAX_TILE_HEIGHT) : 1;
  localparam int TW    = $clog2(MAX_TILE_ROWS + 1);
  localparam int SUM_W = $clog2(MAX_TILE_WIDTH * MAX_TILE_HEIGHT * NUM_CHAN * BYTE_MAX + 1);
  localparam int DV_W  = $clog2(MAX_TILE_WIDTH * MAX_TILE_HEIGHT * NUM_CHAN + 1);

  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_TILE_COLS);
  localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_TILE_WIDTH);
  localparam logic [CMP_W-1:0] MAX_H = CMP_W'(MAX_TILE_HEIGHT);
  localparam logic [CMP_W-1:0] MAX_R = CMP_W'(MAX_TILE_ROWS);

  // Configuration registers.
  logic [6:0] tile_cols;
  logic [5:0] tile_width;
  logic [6:0] tile_height;
  logic [7:0] tile_rows;
  logic [7:0] threshold;
  logic       mask_enable;

  logic [2:0] reg_idx;
  logic       cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_cols   <= 7'd64;
      tile_width  <= 6'd10;
      tile_height <= 7'd7;
      tile_rows   <= 8'd68;
      threshold   <= 8'd20;
      mask_enable <= 1'b0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_TILE_COLS:   tile_cols   <= pwdata[6:0];
        REG_TILE_WIDTH:  tile_width  <= pwdata[5:0];
        REG_TILE_HEIGHT: tile_height <= pwdata[6:0];
        REG_TILE_ROWS:   tile_rows   <= pwdata[7:0];
        REG_THRESHOLD:   threshold   <= pwdata[7:0];
        REG_MASK_ENABLE: mask_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      REG_TILE_COLS:   prdata = 32'(tile_cols);
      REG_TILE_WIDTH:  prdata = 32'(tile_width);
      REG_TILE_HEIGHT: prdata = 32'(tile_height);
      REG_TILE_ROWS:   prdata = 32'(tile_rows);
      REG_THRESHOLD:   prdata = 32'(threshold);
      REG_MASK_ENABLE: prdata = 32'(mask_enable);
      default:         prdata = '0;
    endcase
  end

  // Effective tile geometry.
  logic [CMP_W-1:0] cols_c;
  logic [CMP_W-1:0] w_c;
  logic [CMP_W-1:0] h_c;
  logic [CMP_W-1:0] rows_c;
  logic [2*CMP_W-1:0] wh;
  logic [DV_W-1:0]  divisor;

  assign cols_c = clamp_reg(CMP_W'(tile_cols), MAX_C);
  assign w_c    = clamp_reg(CMP_W'(tile_width), MAX_W);
  assign h_c    = clamp_reg(CMP_W'(tile_height), MAX_H);
  assign rows_c = clamp_reg(CMP_W'(tile_rows), MAX_R);
  assign wh     = (2*CMP_W)'(w_c) * (2*CMP_W)'(h_c);

  // Divisor is width times height times three, registered off the multiplier.
  always_ff @(posedge clk) begin
    divisor <= DV_W'({wh, 1'b0} + {1'b0, wh});
  end

  // Frame position.
  logic [PW-1:0] pix;
  logic [AW-1:0] col;
  logic [RW-1:0] rit;
  logic [TW-1:0] trow;
  logic [PW-1:0] pix_next;
  logic [AW-1:0] col_next;
  logic [RW-1:0] rit_next;
  logic [TW-1:0] trow_next;

  logic [PW-1:0] eff_pix;
  logic [AW-1:0] eff_col;
  logic [RW-1:0] eff_rit;
  logic [TW-1:0] eff_trow;
  logic [CMP_W-1:0] pix_inc;
  logic [CMP_W-1:0] col_inc;
  logic [CMP_W-1:0] rit_inc;
  logic [CMP_W-1:0] trow_inc;
  logic pix_wrap;
  logic col_wrap;
  logic rit_wrap;
  logic skip;
  logic done_now;
  logic last_now;
  logic pix_acc;

  assign pix_acc  = pix_valid && pix_ready;
  assign eff_pix  = start_of_frame ? '0 : pix;
  assign eff_col  = start_of_frame ? '0 : col;
  assign eff_rit  = start_of_frame ? '0 : rit;
  assign eff_trow = start_of_frame ? '0 : trow;
  assign pix_inc  = CMP_W'(eff_pix) + CMP_W'(1);
  assign col_inc  = CMP_W'(eff_col) + CMP_W'(1);
  assign rit_inc  = CMP_W'(eff_rit) + CMP_W'(1);
  assign trow_inc = CMP_W'(eff_trow) + CMP_W'(1);
  assign pix_wrap = (pix_inc >= w_c);
  assign col_wrap = (col_inc >= cols_c);
  assign rit_wrap = (rit_inc >= h_c);
  assign skip     = (CMP_W'(eff_trow) >= rows_c);
  assign done_now = pix_wrap && rit_wrap;
  assign last_now = (trow_inc >= rows_c) && col_wrap;

  // Advance through pixel, tile column, tile row and band.
  always_comb begin
    pix_next  = eff_pix;
    col_next  = eff_col;
    rit_next  = eff_rit;
    trow_next = eff_trow;
    if (!skip) begin
      if (pix_wrap) begin
        pix_next = '0;
        if (col_wrap) begin
          col_next = '0;
          if (rit_wrap) begin
            rit_next  = '0;
            trow_next = TW'(trow_inc);
          end else begin
            rit_next = RW'(rit_inc);
          end
        end else begin
          col_next = AW'(col_inc);
        end
      end else begin
        pix_next = PW'(pix_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix  <= '0;
      col  <= '0;
      rit  <= '0;
      trow <= '0;
    end else if (pix_acc) begin
      pix  <= pix_next;
      col  <= col_next;
      rit  <= rit_next;
      trow <= trow_next;
    end
  end

  // Interlock: a pixel that may finish a tile waits for the divider to free up.
  logic div_busy;
  logic tile_in_flight;
  logic maybe_done;

  assign maybe_done = ((CMP_W'(pix) + CMP_W'(1) >= w_c) && (CMP_W'(rit) + CMP_W'(1) >= h_c))
                      || ((w_c == CMP_W'(1)) && (h_c == CMP_W'(1)));
  assign pix_ready  = !(tile_in_flight && maybe_done);

  // Accumulate stage: the read issued at accept returns here, is added to and written back.
  logic                b_valid;
  logic [AW-1:0]       b_addr;
  logic                b_clear;
  logic [ADD_W-1:0]    b_add;
  logic                b_done;
  tile_tag_t           b_tag;
  logic                fwd_hit;
  logic [SUM_W-1:0]    fwd_data;
  logic [SUM_W-1:0]    ram_rdata;
  logic [SUM_W-1:0]    base;
  logic [SUM_W-1:0]    new_sum;
  logic [ADD_W-1:0]    add_now;
  logic                a_issue;

  assign add_now = ADD_W'(masked_byte(chan0, mask0, mask_enable))
                 + ADD_W'(masked_byte(chan1, mask1, mask_enable))
                 + ADD_W'(masked_byte(chan2, mask2, mask_enable));
  assign a_issue = pix_acc && !skip;
  assign tile_in_flight = (b_valid && b_done) || div_busy;

  always_comb begin
    if (b_clear) begin
      base = '0;
    end else if (fwd_hit) begin
      base = fwd_data;
    end else begin
      base = ram_rdata;
    end
  end
  assign new_sum = base + SUM_W'(b_add);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      b_valid <= a_issue;
      fwd_hit <= a_issue && b_valid && (b_addr == eff_col);
    end
  end

  always_ff @(posedge clk) begin
    fwd_data <= new_sum;
    if (a_issue) begin
      b_addr    <= eff_col;
      b_clear   <= (eff_rit == '0) && (eff_pix == '0);
      b_add     <= add_now;
      b_done    <= done_now;
      b_tag.row <= 7'(eff_trow);
      b_tag.col <= 6'(eff_col);
      b_tag.last <= last_now;
    end
  end

  tmtg_sum_ram #(
    .DEPTH (MAX_TILE_COLS),
    .AW    (AW),
    .DW    (SUM_W)
  ) u_sum_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (a_issue),
    .rd_addr (eff_col),
    .rd_data (ram_rdata),
    .wr_en   (b_valid),
    .wr_addr (b_addr),
    .wr_data (new_sum)
  );

  // Mean of a completed tile.
  logic             div_start;
  logic             q_valid;
  logic             out_load;
  logic [SUM_W-1:0] quotient;
  tile_tag_t        div_tag;

  assign div_start = b_valid && b_done;
  assign out_load  = q_valid && (!tile_valid || tile_ready);

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_tag <= b_tag;
    end
  end

  tmtg_div #(
    .SUM_W (SUM_W),
    .DV_W  (DV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (new_sum),
    .divisor  (divisor),
    .busy     (div_busy),
    .q_valid  (q_valid),
    .q_ready  (out_load),
    .quotient (quotient)
  );

  // Active tally; a frame start seen while a tile is in flight clears it after that tile.
  logic        act;
  logic [13:0] tally;
  logic [13:0] tally_inc;
  logic        clr_pend;
  logic        sof_acc;

  assign act       = (quotient >= SUM_W'(threshold));
  assign tally_inc = (act && (tally != TALLY_MAX)) ? tally + 14'd1 : tally;
  assign sof_acc   = pix_acc && start_of_frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      tally    <= '0;
      clr_pend <= 1'b0;
    end else if (out_load) begin
      tally    <= (clr_pend || sof_acc) ? '0 : tally_inc;
      clr_pend <= 1'b0;
    end else if (sof_acc) begin
      if (tile_in_flight) begin
        clr_pend <= 1'b1;
      end else begin
        tally <= '0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_valid <= 1'b0;
    end else if (out_load) begin
      tile_valid <= 1'b1;
    end else if (tile_ready) begin
      tile_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      tile_row     <= div_tag.row;
      tile_col     <= div_tag.col;
      tile_mean    <= quotient[7:0];
      tile_active  <= act;
      active_count <= tally_inc;
      last_tile    <= div_tag.last;
    end
  end

`ifndef SYNTHESIS
  // A tile only enters the divider when it is free.
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_done |-> !div_busy)
    else $error("tile entered a busy divider");

  // An active tile is always counted.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    tile_valid && tile_active |-> active_count != '0)
    else $error("active tile with zero count");

  // A deferred tally clear only exists while a tile is in flight.
  a_clear_pending: assert property (@(posedge clk) disable iff (rst)
    clr_pend |-> div_busy)
    else $error("pending tally clear with no tile in flight");
`endif

endmodule

// ===== sim/tb_tile_mean_threshold_grid_top.sv =====
module tb_tile_mean_threshold_grid_top import tmtg_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COLS_MAX = 64;
  localparam int WIDTH_MAX = 32;
  localparam int HEIGHT_MAX = 64;
  localparam int ROWS_MAX = 128;
  localparam int RANDOM_ITEMS = 1150;
  localparam int SETTLE_CYCLES = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DIRECTED_ROWS = 18;

  // One pixel beat, in the order of the input ports.
  typedef struct packed {
    logic       sof;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    logic [7:0] m0;
    logic [7:0] m1;
    logic [7:0] m2;
  } pixel_t;

  // One tile result beat.
  typedef struct packed {
    logic [6:0]  row;
    logic [5:0]  col;
    logic [7:0]  mean;
    logic        active;
    logic [13:0] count;
    logic        last;
  } tile_t;

  // A directed row: the pixel, and a hand-written tile result where one is given.
  typedef struct packed {
    pixel_t px;
    logic   typed;
    tile_t  want;
  } vector_t;

  localparam tile_t NO_TILE = '0;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        pix_valid = 1'b0;
  logic        pix_ready;
  logic        start_of_frame = 1'b0;
  logic [7:0]  chan0 = '0;
  logic [7:0]  chan1 = '0;
  logic [7:0]  chan2 = '0;
  logic [7:0]  mask0 = '0;
  logic [7:0]  mask1 = '0;
  logic [7:0]  mask2 = '0;
  logic        tile_valid;
  logic        tile_ready = 1'b0;
  logic [6:0]  tile_row;
  logic [5:0]  tile_col;
  logic [7:0]  tile_mean;
  logic        tile_active;
  logic [13:0] active_count;
  logic        last_tile;

  tile_mean_threshold_grid_top dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pix_valid      (pix_valid),
    .pix_ready      (pix_ready),
    .start_of_frame (start_of_frame),
    .chan0          (chan0),
    .chan1          (chan1),
    .chan2          (chan2),
    .mask0          (mask0),
    .mask1          (mask1),
    .mask2          (mask2),
    .tile_valid     (tile_valid),
    .tile_ready     (tile_ready),
    .tile_row       (tile_row),
    .tile_col       (tile_col),
    .tile_mean      (tile_mean),
    .tile_active    (tile_active),
    .active_count   (active_count),
    .last_tile      (last_tile)
  );

  // Shadow copy of the configuration registers, reset values first.
  logic [6:0] cfg_cols = 7'd64;
  logic [5:0] cfg_width = 6'd10;
  logic [6:0] cfg_height = 7'd7;
  logic [7:0] cfg_rows = 8'd68;
  logic [7:0] cfg_threshold = 8'd20;
  logic       cfg_mask_en = 1'b0;

  // Expected grid position and per-column tile sums.
  int sum_by_col [COLS_MAX];
  int x_in_tile = 0;
  int col_pos = 0;
  int y_in_tile = 0;
  int band_pos = 0;
  int active_seen = 0;

  tile_t   pending_tiles [$];
  vector_t directed_rows [DIRECTED_ROWS];
  int      errors = 0;
  int      work_items = 0;
  bit      hold_sink = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic pixel_t pix(input bit sof, input int c0, input int c1, input int c2,
                                 input int m0, input int m1, input int m2);
    pixel_t p;
    p.sof = sof;
    p.c0 = 8'(c0);
    p.c1 = 8'(c1);
    p.c2 = 8'(c2);
    p.m0 = 8'(m0);
    p.m1 = 8'(m1);
    p.m2 = 8'(m2);
    return p;
  endfunction

  function automatic tile_t tile(input int row, input int col, input int mean, input bit act,
                                 input int cnt, input bit last);
    tile_t t;
    t.row = 7'(row);
    t.col = 6'(col);
    t.mean = 8'(mean);
    t.active = act;
    t.count = 14'(cnt);
    t.last = last;
    return t;
  endfunction

  // A zero size acts as one; a size past the maximum saturates.
  function automatic int dim_limit(input int v, input int top);
    return (v == 0) ? 1 : ((v > top) ? top : v);
  endfunction

  function automatic int byte_kept(input logic [7:0] chan, input logic [7:0] mask);
    return (cfg_mask_en && mask > MASK_LIMIT) ? 0 : int'(chan);
  endfunction

  // Advance the expected grid by one pixel and work out the tile it completes.
  task automatic tile_grid_step(input pixel_t px, output bit counted, output bit got,
                                output tile_t t);
    int cols, w, h, rows, c, mean;
    cols = dim_limit(cfg_cols, COLS_MAX);
    w = dim_limit(cfg_width, WIDTH_MAX);
    h = dim_limit(cfg_height, HEIGHT_MAX);
    rows = dim_limit(cfg_rows, ROWS_MAX);
    counted = 1'b0;
    got = 1'b0;
    t = NO_TILE;
    if (px.sof) begin
      x_in_tile = 0;
      col_pos = 0;
      y_in_tile = 0;
      band_pos = 0;
      active_seen = 0;
    end
    // Once the last band is done the frame ignores pixels.
    if (band_pos < rows) begin
      counted = 1'b1;
      c = col_pos % COLS_MAX;
      if (y_in_tile == 0 && x_in_tile == 0) sum_by_col[c] = 0;
      sum_by_col[c] += byte_kept(px.c0, px.m0) + byte_kept(px.c1, px.m1) +
                       byte_kept(px.c2, px.m2);
      if (x_in_tile + 1 >= w && y_in_tile + 1 >= h) begin
        mean = sum_by_col[c] / (w * h * 3);
        got = 1'b1;
        if (mean >= cfg_threshold && active_seen < TALLY_MAX) active_seen++;
        t.row = 7'(band_pos);
        t.col = 6'(col_pos);
        t.mean = 8'(mean);
        t.active = (mean >= cfg_threshold);
        t.count = 14'(active_seen);
        t.last = (band_pos + 1 >= rows && col_pos + 1 >= cols);
      end
      // Counters at or past a limit wrap on their next advance.
      x_in_tile++;
      if (x_in_tile >= w) begin
        x_in_tile = 0;
        col_pos++;
        if (col_pos >= cols) begin
          col_pos = 0;
          y_in_tile++;
          if (y_in_tile >= h) begin
            y_in_tile = 0;
            band_pos++;
          end
        end
      end
    end
  endtask

  // Register write: setup phase, access phase, then an idle wait before returning.
  task automatic set_reg(input logic [2:0] idx, input int unsigned value);
    logic [31:0] word;
    word = ($urandom_range(0, 3) == 0) ? (($urandom << 8) | value) : value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TILE_COLS:   cfg_cols = word[6:0];
      REG_TILE_WIDTH:  cfg_width = word[5:0];
      REG_TILE_HEIGHT: cfg_height = word[6:0];
      REG_TILE_ROWS:   cfg_rows = word[7:0];
      REG_THRESHOLD:   cfg_threshold = word[7:0];
      REG_MASK_ENABLE: cfg_mask_en = word[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offer one pixel beat after a gap, and predict once it is taken.
  task automatic offer_pixel(input pixel_t px, input int gap, output bit counted,
                             output bit got, output tile_t t);
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    {start_of_frame, chan0, chan1, chan2, mask0, mask1, mask2} <= px;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    tile_grid_step(px, counted, got, t);
    if (counted) work_items++;
  endtask

  // Stop offering, wait for every tile in flight, then let the pipeline go quiet.
  task automatic settle();
    pix_valid <= 1'b0;
    while (pending_tiles.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // One random phase: new or partly carried-over settings, then frames of pixels around one level.
  task automatic run_phase(input int idx);
    int style, sel, cols, w, h, rows, thr, lvl, spread, dens, frames, len, span, gap;
    bit cont, quiet, counted, got;
    pixel_t px;
    tile_t t;
    settle();
    style = $urandom_range(0, 11);
    sel = $urandom_range(0, 2);
    cols = $urandom_range(1, 4);
    w = $urandom_range(1, 3);
    h = $urandom_range(1, 3);
    rows = $urandom_range(1, 3);
    cont = (idx > 0) && ($urandom_range(0, 3) == 0);
    quiet = ($urandom_range(0, 2) == 0);
    // Extremes of one size at a time; the others among columns, width and height are kept at one.
    case (style)
      0: begin
        cols = (sel == 0) ? 0 : ((sel == 1) ? 64 : $urandom_range(65, 127));
        w = 1;
        h = 1;
      end
      1: begin
        w = (sel == 0) ? 0 : ((sel == 1) ? 32 : $urandom_range(33, 63));
        cols = 1;
        h = 1;
      end
      2: begin
        h = (sel == 0) ? 0 : ((sel == 1) ? 64 : $urandom_range(65, 127));
        cols = 1;
        w = 1;
        rows = $urandom_range(1, 2);
      end
      3: begin
        rows = (sel == 0) ? 0 : ((sel == 1) ? 128 : $urandom_range(129, 255));
        cols = 1;
        w = 1;
        h = 1;
      end
      default: ;
    endcase
    // Enough tiles behind a stalled receiver to back up the pixel channel.
    if (idx == 2) begin
      cols = 4;
      w = 1;
      h = 1;
      rows = 32;
      cont = 1'b0;
      quiet = 1'b1;
      hold_sink = 1'b1;
    end
    lvl = $urandom_range(0, 255);
    case ($urandom_range(0, 3))
      0: spread = 0;
      1: spread = 8'h0F;
      2: spread = 8'hFF;
      default: spread = $urandom_range(0, 255);
    endcase
    case ($urandom_range(0, 3))
      0: thr = 0;
      1: thr = 255;
      2: thr = $urandom_range(0, 255);
      default: thr = lvl;
    endcase
    dens = $urandom_range(0, 3);
    if (!cont || $urandom_range(0, 1)) set_reg(REG_TILE_COLS, cols);
    if (!cont || $urandom_range(0, 1)) set_reg(REG_TILE_WIDTH, w);
    if (!cont || $urandom_range(0, 1)) set_reg(REG_TILE_HEIGHT, h);
    if (!cont || $urandom_range(0, 1)) set_reg(REG_TILE_ROWS, rows);
    if (!cont || $urandom_range(0, 1)) set_reg(REG_THRESHOLD, thr);
    if (!cont || $urandom_range(0, 1)) set_reg(REG_MASK_ENABLE, $urandom_range(0, 1));
    span = dim_limit(cfg_cols, COLS_MAX) * dim_limit(cfg_width, WIDTH_MAX) *
           dim_limit(cfg_height, HEIGHT_MAX) * dim_limit(cfg_rows, ROWS_MAX);
    frames = (span <= 40) ? $urandom_range(1, 4) : 1;
    for (int f = 0; f < frames; f++) begin
      len = (span > 160) ? $urandom_range(40, 160) : span;
      // Now and then a frame is cut short, or runs past its end.
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
      if ($urandom_range(0, 3) == 0) len += $urandom_range(1, 3);
      for (int i = 0; i < len; i++) begin
        px.sof = (i == 0 && !(cont && f == 0)) || ($urandom_range(0, 299) == 0);
        px.c0 = 8'(lvl ^ ($urandom & spread));
        px.c1 = 8'(lvl ^ ($urandom & spread));
        px.c2 = 8'(lvl ^ ($urandom & spread));
        px.m0 = ($urandom_range(0, 3) < dens) ? 8'($urandom_range(129, 255))
                                              : 8'($urandom_range(0, 128));
        px.m1 = ($urandom_range(0, 3) < dens) ? 8'($urandom_range(129, 255))
                                              : 8'($urandom_range(0, 128));
        px.m2 = ($urandom_range(0, 3) < dens) ? 8'($urandom_range(129, 255))
                                              : 8'($urandom_range(0, 128));
        gap = quiet ? 0 : $urandom_range(0, 19);
        offer_pixel(px, gap, counted, got, t);
        if (got) pending_tiles.push_back(t);
      end
    end
  endtask

  // Directed rows run with tiles of one pixel, two columns, two bands,
  // threshold 128 and masking on.
  initial begin
    directed_rows[0]  = '{pix(1, 255, 255, 255, 0, 0, 0), 1'b1, tile(0, 0, 255, 1, 1, 0)};
    directed_rows[1]  = '{pix(0, 0, 0, 0, 255, 255, 255), 1'b1, tile(0, 1, 0, 0, 1, 0)};
    directed_rows[2]  = '{pix(0, 255, 255, 255, 128, 128, 128), 1'b1,
                          tile(1, 0, 255, 1, 2, 0)};
    directed_rows[3]  = '{pix(0, 255, 255, 255, 129, 129, 129), 1'b1,
                          tile(1, 1, 0, 0, 2, 1)};
    // Frame finished: this pixel is ignored.
    directed_rows[4]  = '{pix(0, 17, 34, 51, 0, 0, 0), 1'b0, NO_TILE};
    directed_rows[5]  = '{pix(1, 128, 127, 129, 255, 0, 0), 1'b1, tile(0, 0, 85, 0, 0, 0)};
    directed_rows[6]  = '{pix(0, 128, 128, 128, 0, 0, 0), 1'b1, tile(0, 1, 128, 1, 1, 0)};
    directed_rows[7]  = '{pix(0, 127, 127, 127, 0, 0, 0), 1'b1, tile(1, 0, 127, 0, 1, 0)};
    // Start of frame in the middle of a frame drops the partial frame.
    directed_rows[8]  = '{pix(1, 255, 0, 0, 0, 129, 129), 1'b1, tile(0, 0, 85, 0, 0, 0)};
    directed_rows[9]  = '{pix(0, 0, 255, 0, 128, 127, 129), 1'b1, tile(0, 1, 85, 0, 0, 0)};
    directed_rows[10] = '{pix(0, 255, 255, 0, 1, 2, 4), 1'b1, tile(1, 0, 170, 1, 1, 0)};
    directed_rows[11] = '{pix(1, 170, 85, 240, 15, 195, 60), 1'b0, NO_TILE};
    directed_rows[12] = '{pix(0, 85, 170, 15, 240, 60, 195), 1'b0, NO_TILE};
    directed_rows[13] = '{pix(0, 1, 2, 4, 8, 16, 32), 1'b0, NO_TILE};
    directed_rows[14] = '{pix(0, 254, 253, 251, 247, 239, 223), 1'b0, NO_TILE};
    directed_rows[15] = '{pix(0, 64, 32, 16, 0, 0, 0), 1'b0, NO_TILE};
    directed_rows[16] = '{pix(1, 128, 64, 32, 127, 126, 125), 1'b0, NO_TILE};
    directed_rows[17] = '{pix(0, 254, 127, 191, 130, 1, 64), 1'b0, NO_TILE};
  end

  // Tile sink: random stalls, long hold-off on request, and checking.
  initial begin : tile_sink
    int gap, beats;
    tile_t want;
    beats = 0;
    while (rst) @(posedge clk);
    forever begin
      gap = (((beats / 40) % 3) == 0) ? 0 : $urandom_range(0, 19);
      if (hold_sink) begin
        hold_sink = 1'b0;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        tile_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      tile_ready <= 1'b1;
      @(posedge clk);
      while (!tile_valid) @(posedge clk);
      if (pending_tiles.size() == 0) begin
        $display("%0t: tile beat with nothing expected: row %0d col %0d mean %0d",
                 $time, tile_row, tile_col, tile_mean);
        errors++;
      end else begin
        want = pending_tiles.pop_front();
        check_field("tile_row", want.row, tile_row);
        check_field("tile_col", want.col, tile_col);
        check_field("tile_mean", want.mean, tile_mean);
        check_field("tile_active", want.active, tile_active);
        check_field("active_count", want.count, active_count);
        check_field("last_tile", want.last, last_tile);
      end
      beats++;
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((pix_valid && pix_ready) || (tile_valid && tile_ready)) idle = 0;
      else idle++;
    end
    $display("tb_tile_mean_threshold_grid_top: FAIL");
    $finish;
  end

  // Reset, directed rows, random phases, then drain and report.
  initial begin : pixel_source
    int phase;
    bit counted, got;
    tile_t t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    set_reg(REG_TILE_COLS, 2);
    set_reg(REG_TILE_WIDTH, 1);
    set_reg(REG_TILE_HEIGHT, 1);
    set_reg(REG_TILE_ROWS, 2);
    set_reg(REG_THRESHOLD, 128);
    set_reg(REG_MASK_ENABLE, 1);
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_pixel(directed_rows[i].px, $urandom_range(0, 19), counted, got, t);
      if (directed_rows[i].typed) pending_tiles.push_back(directed_rows[i].want);
      else if (got) pending_tiles.push_back(t);
    end
    work_items = 0;
    phase = 0;
    while (work_items < RANDOM_ITEMS) begin
      run_phase(phase);
      phase++;
    end
    settle();
    if (errors == 0 && pending_tiles.size() == 0) begin
      $display("tb_tile_mean_threshold_grid_top: PASS");
    end else begin
      $display("tb_tile_mean_threshold_grid_top: FAIL");
    end
    $finish;
  end

endmodule
